FILE: design/rbag_pkg.sv
`timescale 1ns / 1ps

package rbag_pkg;

    // Largest surface dimension; register values above it are treated as this.
    localparam int unsigned MAX_DIM = 4096;

    localparam int unsigned DIM_W   = 13;  // surface and copy sizes
    localparam int unsigned COORD_W = 12;  // clamped row and column
    localparam int unsigned SUM_W   = 14;  // origin plus scan position
    localparam int unsigned IDX_W   = 24;  // pixel index
    localparam int unsigned PROD_W  = COORD_W + DIM_W;

    localparam logic [1:0] REG_SRC_WIDTH  = 2'd0;
    localparam logic [1:0] REG_SRC_HEIGHT = 2'd1;
    localparam logic [1:0] REG_DST_WIDTH  = 2'd2;
    localparam logic [1:0] REG_DST_HEIGHT = 2'd3;

    localparam logic FUNC_START   = 1'b0;
    localparam logic FUNC_ADVANCE = 1'b1;

    // Clamped coordinates of one pixel pair on their way to the index multiplier.
    typedef struct packed {
        logic [COORD_W-1:0] src_row;
        logic [COORD_W-1:0] src_col;
        logic [COORD_W-1:0] dst_row;
        logic [COORD_W-1:0] dst_col;
        logic               last;
    } t_coord_req;

    // A zero register acts as one and an oversized one as MAX_DIM.
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] res;
        if (v == '0) begin
            res = DIM_W'(1);
        end else if (32'(v) > MAX_DIM) begin
            res = DIM_W'(MAX_DIM);
        end else begin
            res = v;
        end
        return res;
    endfunction

    function automatic logic [COORD_W-1:0] clamp_coord(input logic [SUM_W-1:0] c,
                                                       input logic [DIM_W-1:0] lim);
        logic [COORD_W-1:0] res;
        if (c >= SUM_W'(lim)) begin
            res = COORD_W'(lim - DIM_W'(1));
        end else begin
            res = COORD_W'(c);
        end
        return res;
    endfunction

endpackage

FILE: design/rbag_index_unit.sv
`timescale 1ns / 1ps

module rbag_index_unit
    import rbag_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    input  t_coord_req         i_req,
    output logic               o_req_stall,
    input  logic [DIM_W-1:0]   i_src_width,
    input  logic [DIM_W-1:0]   i_dst_width,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [IDX_W-1:0]   o_src_index,
    output logic [IDX_W-1:0]   o_dst_index,
    output logic               o_last
);

    logic              r_valid;
    logic [IDX_W-1:0]  r_src_index;
    logic [IDX_W-1:0]  r_dst_index;
    logic              r_last;

    logic [PROD_W-1:0] n_src_sum;
    logic [PROD_W-1:0] n_dst_sum;
    logic              take;

    assign take        = !r_valid || !i_stall;
    assign o_req_stall = !take;

    assign n_src_sum = PROD_W'(i_req.src_row) * PROD_W'(i_src_width) + PROD_W'(i_req.src_col);
    assign n_dst_sum = PROD_W'(i_req.dst_row) * PROD_W'(i_dst_width) + PROD_W'(i_req.dst_col);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= i_req_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && i_req_valid) begin
            r_src_index <= n_src_sum[IDX_W-1:0];
            r_dst_index <= n_dst_sum[IDX_W-1:0];
            r_last      <= i_req.last;
        end
    end

    assign o_valid     = r_valid;
    assign o_src_index = r_src_index;
    assign o_dst_index = r_dst_index;
    assign o_last      = r_last;

endmodule

FILE: design/rect_blit_address_generator.sv
`timescale 1ns / 1ps

// Rectangle blit address generator. A start request latches the copy rectangle and
// gives no result; each advance request while a blit is active gives one source and
// destination pixel index pair, scanning across a row and then down, with the final
// pair flagged by o_last. One request is taken every cycle while o_in_stall is low;
// each pair is registered first in the clamp stage and then in the row-times-width
// multiplier stage. Surface registers may only be written while no
// pair is in flight.
module rect_blit_address_generator
    import rbag_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [DIM_W-1:0]   i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_func,
    input  logic [COORD_W-1:0] i_src_col,
    input  logic [COORD_W-1:0] i_src_row,
    input  logic [COORD_W-1:0] i_dst_col,
    input  logic [COORD_W-1:0] i_dst_row,
    input  logic [DIM_W-1:0]   i_copy_width,
    input  logic [DIM_W-1:0]   i_copy_height,
    input  logic               i_whole_source,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [IDX_W-1:0]   o_src_index,
    output logic [IDX_W-1:0]   o_dst_index,
    output logic               o_last
);

    logic [DIM_W-1:0]   r_src_width, r_src_height, r_dst_width, r_dst_height;
    logic [DIM_W-1:0]   r_row_count, r_col_count;
    logic [COORD_W-1:0] r_saved_src_col, r_saved_src_row;
    logic [COORD_W-1:0] r_saved_dst_col, r_saved_dst_row;
    logic [DIM_W-1:0]   r_saved_width, r_saved_height;
    logic               r_busy;
    logic               r_a_valid;
    t_coord_req         r_a;

    logic [DIM_W-1:0]   eff_src_w, eff_src_h, eff_dst_w, eff_dst_h;
    logic               accept, advance, end_col, end_row, fin;
    logic               req_stall;
    t_coord_req         n_a;

    assign eff_src_w = eff_dim(r_src_width);
    assign eff_src_h = eff_dim(r_src_height);
    assign eff_dst_w = eff_dim(r_dst_width);
    assign eff_dst_h = eff_dim(r_dst_height);

    assign o_in_stall = r_a_valid && req_stall;
    assign accept     = i_in_valid && !o_in_stall;
    assign advance    = accept && (i_func == FUNC_ADVANCE) && r_busy;

    assign end_col = (DIM_W + 1)'(r_col_count) + 14'd1 >= (DIM_W + 1)'(r_saved_width);
    assign end_row = (DIM_W + 1)'(r_row_count) + 14'd1 >= (DIM_W + 1)'(r_saved_height);
    assign fin     = end_col && end_row;

    always_comb begin
        n_a.src_row = clamp_coord(SUM_W'(r_saved_src_row) + SUM_W'(r_row_count), eff_src_h);
        n_a.src_col = clamp_coord(SUM_W'(r_saved_src_col) + SUM_W'(r_col_count), eff_src_w);
        n_a.dst_row = clamp_coord(SUM_W'(r_saved_dst_row) + SUM_W'(r_row_count), eff_dst_h);
        n_a.dst_col = clamp_coord(SUM_W'(r_saved_dst_col) + SUM_W'(r_col_count), eff_dst_w);
        n_a.last    = fin;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width  <= DIM_W'(640);
            r_src_height <= DIM_W'(480);
            r_dst_width  <= DIM_W'(640);
            r_dst_height <= DIM_W'(480);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_SRC_WIDTH:  r_src_width  <= i_cfg_data;
                REG_SRC_HEIGHT: r_src_height <= i_cfg_data;
                REG_DST_WIDTH:  r_dst_width  <= i_cfg_data;
                REG_DST_HEIGHT: r_dst_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count     <= '0;
            r_col_count     <= '0;
            r_saved_src_col <= '0;
            r_saved_src_row <= '0;
            r_saved_dst_col <= '0;
            r_saved_dst_row <= '0;
            r_saved_width   <= '0;
            r_saved_height  <= '0;
            r_busy          <= 1'b0;
        end else if (accept && (i_func == FUNC_START)) begin
            r_row_count     <= '0;
            r_col_count     <= '0;
            r_saved_dst_col <= i_dst_col;
            r_saved_dst_row <= i_dst_row;
            if (i_whole_source) begin
                r_saved_src_col <= '0;
                r_saved_src_row <= '0;
                r_saved_width   <= eff_src_w;
                r_saved_height  <= eff_src_h;
                r_busy          <= 1'b1;
            end else begin
                r_saved_src_col <= i_src_col;
                r_saved_src_row <= i_src_row;
                r_saved_width   <= i_copy_width;
                r_saved_height  <= i_copy_height;
                r_busy          <= (i_copy_width != '0) && (i_copy_height != '0);
            end
        end else if (advance) begin
            if (fin) begin
                r_busy      <= 1'b0;
                r_row_count <= '0;
                r_col_count <= '0;
            end else if (end_col) begin
                r_col_count <= '0;
                r_row_count <= r_row_count + DIM_W'(1);
            end else begin
                r_col_count <= r_col_count + DIM_W'(1);
            end
        end
    end

    // Clamp stage: holds the coordinates of one pair until the multiplier takes them.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_a_valid <= advance;
        end else if (!req_stall) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_a <= n_a;
        end
    end

    rbag_index_unit u_index (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (r_a_valid),
        .i_req       (r_a),
        .o_req_stall (req_stall),
        .i_src_width (eff_src_w),
        .i_dst_width (eff_dst_w),
        .o_valid     (o_out_valid),
        .i_stall     (i_out_stall),
        .o_src_index (o_src_index),
        .o_dst_index (o_dst_index),
        .o_last      (o_last)
    );

    a_idle_counts_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_row_count == '0) && (r_col_count == '0))
        else $error("scan position not cleared while no blit is active");

    a_scan_in_rect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_col_count < r_saved_width) && (r_row_count < r_saved_height))
        else $error("scan position outside the latched rectangle");

    a_last_ends_blit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && fin && !(accept && (i_func == FUNC_START)) |=> !r_busy)
        else $error("blit still active after its final pair");

    a_stage_only_on_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall && !advance |=> !r_a_valid)
        else $error("clamp stage loaded without an active advance");

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps

module tb;
    import rbag_pkg::*;

    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned LONG_HOLD     = 400;
    localparam int unsigned QUIET_LIMIT   = 4000;

    typedef struct packed {
        logic               func;
        logic [COORD_W-1:0] src_col;
        logic [COORD_W-1:0] src_row;
        logic [COORD_W-1:0] dst_col;
        logic [COORD_W-1:0] dst_row;
        logic [DIM_W-1:0]   copy_width;
        logic [DIM_W-1:0]   copy_height;
        logic               whole_source;
    } t_blit_req;

    typedef struct packed {
        logic [IDX_W-1:0] src_index;
        logic [IDX_W-1:0] dst_index;
        logic             last;
    } t_pixel_pair;

    // Tracks the scan position of the current blit and the pixel pairs it still owes.
    class blit_tracker;
        logic [DIM_W-1:0] surface_reg [4];
        int unsigned row_pos, col_pos;
        int unsigned src_col0, src_row0, dst_col0, dst_row0;
        int unsigned rect_w, rect_h;
        bit          active;
        t_pixel_pair pending_pairs[$];
        int unsigned mismatches, pairs_checked, blits_done;

        function new();
            surface_reg[REG_SRC_WIDTH]  = 13'd640;
            surface_reg[REG_SRC_HEIGHT] = 13'd480;
            surface_reg[REG_DST_WIDTH]  = 13'd640;
            surface_reg[REG_DST_HEIGHT] = 13'd480;
            row_pos = 0;
            col_pos = 0;
            src_col0 = 0;
            src_row0 = 0;
            dst_col0 = 0;
            dst_row0 = 0;
            rect_w = 0;
            rect_h = 0;
            active = 1'b0;
            mismatches = 0;
            pairs_checked = 0;
            blits_done = 0;
        endfunction

        // A zero register behaves as one, anything past MAX_DIM as MAX_DIM.
        function int unsigned surface_dim(logic [DIM_W-1:0] v);
            return (v == '0) ? 1 : ((int'(v) > int'(MAX_DIM)) ? MAX_DIM : int'(v));
        endfunction

        function int unsigned clamped_index(int unsigned row0, int unsigned col0,
                                           logic [DIM_W-1:0] wreg, logic [DIM_W-1:0] hreg);
            int unsigned w, h, r, c;
            w = surface_dim(wreg);
            h = surface_dim(hreg);
            r = row0 + row_pos;
            c = col0 + col_pos;
            if (r >= h) r = h - 1;
            if (c >= w) c = w - 1;
            return (r * w + c) & 32'h00FF_FFFF;
        endfunction

        // Returns 1 when the request had any effect on the block.
        function bit note_request(t_blit_req q);
            t_pixel_pair p;
            bit end_col, end_row;
            if (q.func == FUNC_START) begin
                dst_col0 = q.dst_col;
                dst_row0 = q.dst_row;
                if (q.whole_source) begin
                    src_col0 = 0;
                    src_row0 = 0;
                    rect_w = surface_dim(surface_reg[REG_SRC_WIDTH]);
                    rect_h = surface_dim(surface_reg[REG_SRC_HEIGHT]);
                end else begin
                    src_col0 = q.src_col;
                    src_row0 = q.src_row;
                    rect_w = q.copy_width;
                    rect_h = q.copy_height;
                end
                row_pos = 0;
                col_pos = 0;
                active = (rect_w != 0) && (rect_h != 0);
                return 1'b1;
            end
            if (!active) return 1'b0;
            p.src_index = IDX_W'(clamped_index(src_row0, src_col0,
                                               surface_reg[REG_SRC_WIDTH],
                                               surface_reg[REG_SRC_HEIGHT]));
            p.dst_index = IDX_W'(clamped_index(dst_row0, dst_col0,
                                               surface_reg[REG_DST_WIDTH],
                                               surface_reg[REG_DST_HEIGHT]));
            end_col = (col_pos + 1 >= rect_w);
            end_row = (row_pos + 1 >= rect_h);
            p.last = end_col && end_row;
            pending_pairs.push_back(p);
            if (p.last) begin
                active = 1'b0;
                row_pos = 0;
                col_pos = 0;
            end else if (end_col) begin
                col_pos = 0;
                row_pos++;
            end else begin
                col_pos++;
            end
            return 1'b1;
        endfunction

        function void check_pair(t_pixel_pair got);
            t_pixel_pair want;
            if (pending_pairs.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected pair: src %0d dst %0d last %0b",
                             got.src_index, got.dst_index, got.last);
                return;
            end
            want = pending_pairs.pop_front();
            pairs_checked++;
            if (want.last) blits_done++;
            if (got.src_index !== want.src_index || got.dst_index !== want.dst_index ||
                got.last !== want.last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("pair %0d expected src/dst/last %0d/%0d/%0b, got %0d/%0d/%0b",
                             pairs_checked, want.src_index, want.dst_index, want.last,
                             got.src_index, got.dst_index, got.last);
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [1:0]         i_cfg_index;
    logic [DIM_W-1:0]   i_cfg_data;
    logic               i_in_valid;
    logic               o_in_stall;
    logic               i_func;
    logic [COORD_W-1:0] i_src_col;
    logic [COORD_W-1:0] i_src_row;
    logic [COORD_W-1:0] i_dst_col;
    logic [COORD_W-1:0] i_dst_row;
    logic [DIM_W-1:0]   i_copy_width;
    logic [DIM_W-1:0]   i_copy_height;
    logic               i_whole_source;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [IDX_W-1:0]   o_src_index;
    logic [IDX_W-1:0]   o_dst_index;
    logic               o_last;

    blit_tracker tracker;
    bit          calm = 1'b0;
    bit          long_hold_req = 1'b0;
    int unsigned requests_sent = 0;
    int unsigned phase_items = 0;
    int unsigned settings_used = 1;
    int unsigned holds_done = 0;

    rect_blit_address_generator dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_func         (i_func),
        .i_src_col      (i_src_col),
        .i_src_row      (i_src_row),
        .i_dst_col      (i_dst_col),
        .i_dst_row      (i_dst_row),
        .i_copy_width   (i_copy_width),
        .i_copy_height  (i_copy_height),
        .i_whole_source (i_whole_source),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_src_index    (o_src_index),
        .o_dst_index    (o_dst_index),
        .o_last         (o_last)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic t_blit_req start_request(input logic [COORD_W-1:0] sc, sr, dc, dr,
                                                input logic [DIM_W-1:0] w, h,
                                                input logic whole);
        t_blit_req q;
        q.func = FUNC_START;
        q.src_col = sc;
        q.src_row = sr;
        q.dst_col = dc;
        q.dst_row = dr;
        q.copy_width = w;
        q.copy_height = h;
        q.whole_source = whole;
        return q;
    endfunction

    // Fields other than func are ignored on an advance, so they carry noise.
    function automatic t_blit_req advance_request();
        t_blit_req q;
        q.func = FUNC_ADVANCE;
        q.src_col = COORD_W'($urandom);
        q.src_row = COORD_W'($urandom);
        q.dst_col = COORD_W'($urandom);
        q.dst_row = COORD_W'($urandom);
        q.copy_width = DIM_W'($urandom_range(0, 4096));
        q.copy_height = DIM_W'($urandom_range(0, 4096));
        q.whole_source = 1'($urandom);
        return q;
    endfunction

    // Origins inside the surface, close to its far edge, or anywhere at all.
    function automatic logic [COORD_W-1:0] pick_coord(input int unsigned dim);
        int unsigned v;
        case ($urandom_range(0, 2))
            0: begin
                v = $urandom_range(0, 4095);
            end
            1: begin
                v = $urandom_range(0, dim - 1);
            end
            default: begin
                v = (dim > 4) ? dim - $urandom_range(1, 4) + $urandom_range(0, 3)
                              : $urandom_range(0, 3);
            end
        endcase
        if (v > 4095) v = 4095;
        return COORD_W'(v);
    endfunction

    task automatic push_request(input t_blit_req q);
        int unsigned gap;
        gap = calm ? 0 : $urandom_range(0, 3);
        repeat (gap) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_func         <= q.func;
        i_src_col      <= q.src_col;
        i_src_row      <= q.src_row;
        i_dst_col      <= q.dst_col;
        i_dst_row      <= q.dst_row;
        i_copy_width   <= q.copy_width;
        i_copy_height  <= q.copy_height;
        i_whole_source <= q.whole_source;
        i_in_valid     <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        requests_sent++;
        if (tracker.note_request(q)) phase_items++;
        @(negedge i_clk);
    endtask

    task automatic drain_and_settle();
        i_in_valid <= 1'b0;
        while (tracker.pending_pairs.size() != 0) @(negedge i_clk);
        // Start requests and idle advances leave nothing to wait on, so give the
        // pipeline time to empty before touching the surface registers.
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [DIM_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        tracker.surface_reg[idx] = val;
        @(negedge i_clk);
    endtask

    task automatic write_surfaces(input logic [DIM_W-1:0] sw, sh, dw, dh);
        drain_and_settle();
        write_register(REG_SRC_WIDTH, sw);
        write_register(REG_SRC_HEIGHT, sh);
        write_register(REG_DST_WIDTH, dw);
        write_register(REG_DST_HEIGHT, dh);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    // A start with a small rectangle followed by the advances it needs, now and then one more.
    task automatic run_small_blit();
        int unsigned sw, sh, dw, dh;
        logic [DIM_W-1:0] w, h;
        bit whole;
        sw = tracker.surface_dim(tracker.surface_reg[REG_SRC_WIDTH]);
        sh = tracker.surface_dim(tracker.surface_reg[REG_SRC_HEIGHT]);
        dw = tracker.surface_dim(tracker.surface_reg[REG_DST_WIDTH]);
        dh = tracker.surface_dim(tracker.surface_reg[REG_DST_HEIGHT]);
        whole = (sw * sh <= 64) && ($urandom_range(0, 3) == 0);
        w = ($urandom_range(0, 7) == 0) ? DIM_W'($urandom_range(1, 16))
                                        : DIM_W'($urandom_range(1, 6));
        h = (w > 6) ? DIM_W'($urandom_range(1, 3)) : DIM_W'($urandom_range(1, 6));
        push_request(start_request(pick_coord(sw), pick_coord(sh), pick_coord(dw),
                                   pick_coord(dh), w, h, whole));
        while (tracker.active) push_request(advance_request());
        if ($urandom_range(0, 4) == 0) push_request(advance_request());
    endtask

    task automatic random_phase(input int unsigned target);
        int unsigned kind;
        t_blit_req q;
        phase_items = 0;
        while (phase_items < target) begin
            kind = $urandom_range(0, 9);
            if (kind <= 6) begin
                run_small_blit();
            end else if (kind == 7) begin
                // Large rectangle, abandoned by the next start.
                push_request(start_request(COORD_W'($urandom), COORD_W'($urandom),
                                           COORD_W'($urandom), COORD_W'($urandom),
                                           $urandom_range(0, 1) ? DIM_W'(4096)
                                                                : DIM_W'($urandom_range(17, 4096)),
                                           DIM_W'($urandom_range(17, 4096)),
                                           1'($urandom)));
                repeat ($urandom_range(0, 5)) push_request(advance_request());
            end else if (kind == 8) begin
                q = advance_request();
                q.func = 1'($urandom);
                push_request(q);
            end else begin
                if ($urandom_range(0, 1))
                    q = start_request(COORD_W'($urandom), COORD_W'($urandom),
                                      COORD_W'($urandom), COORD_W'($urandom),
                                      '0, DIM_W'($urandom_range(0, 4096)), 1'b0);
                else
                    q = start_request(COORD_W'($urandom), COORD_W'($urandom),
                                      COORD_W'($urandom), COORD_W'($urandom),
                                      DIM_W'($urandom_range(0, 4096)), '0, 1'b0);
                push_request(q);
                push_request(advance_request());
            end
        end
    endtask

    initial begin : receiver
        t_pixel_pair got;
        int unsigned n;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge i_clk);
                long_hold_req = 1'b0;
                holds_done++;
            end
            n = calm ? 0 : $urandom_range(0, 3);
            if (n != 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
            got.src_index = o_src_index;
            got.dst_index = o_dst_index;
            got.last      = o_last;
            tracker.check_pair(got);
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        wait (i_rst_n === 1'b1);
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we)
                quiet = 0;
            else
                quiet++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : stimulus
        tracker = new();
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = REG_SRC_WIDTH;
        i_cfg_data     = '0;
        i_in_valid     = 1'b0;
        i_func         = FUNC_START;
        i_src_col      = '0;
        i_src_row      = '0;
        i_dst_col      = '0;
        i_dst_row      = '0;
        i_copy_width   = '0;
        i_copy_height  = '0;
        i_whole_source = 1'b0;
        i_out_stall    = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed requests on the reset surface sizes.
        push_request(advance_request());
        push_request(start_request('0, '0, '0, '0, 13'd2, 13'd2, 1'b0));
        repeat (4) push_request(advance_request());
        push_request(start_request(12'd4095, 12'd4095, 12'd4095, 12'd4095, 13'd1, 13'd1, 1'b0));
        push_request(advance_request());
        push_request(start_request(12'd5, 12'd5, 12'd5, 12'd5, 13'd0, 13'd5, 1'b0));
        push_request(advance_request());
        push_request(start_request(12'd5, 12'd5, 12'd5, 12'd5, 13'd5, 13'd0, 1'b0));
        push_request(advance_request());
        push_request(start_request('0, '0, 12'd100, 12'd100, 13'd4096, 13'd4096, 1'b0));
        repeat (2) push_request(advance_request());
        push_request(start_request(12'd4095, 12'd4095, 12'd3, 12'd2, '0, '0, 1'b1));
        repeat (2) push_request(advance_request());
        push_request(start_request(12'd638, 12'd479, 12'd639, 12'd0, 13'd3, 13'd2, 1'b0));
        repeat (6) push_request(advance_request());

        random_phase(250);

        write_surfaces(13'd1, 13'd1, 13'd1, 13'd1);
        random_phase(270);

        // The receiver holds off long enough for the pipeline to back up into the input.
        write_surfaces(13'd4096, 13'd4096, 13'd4096, 13'd4096);
        long_hold_req = 1'b1;
        push_request(start_request('0, '0, '0, '0, 13'd8, 13'd8, 1'b0));
        while (tracker.active) push_request(advance_request());
        random_phase(270);

        write_surfaces(13'd0, 13'd8191, 13'd4097, 13'd0);
        random_phase(270);

        write_surfaces(13'd5, 13'd3, 13'd7, 13'd4);
        calm = 1'b1;
        random_phase(270);
        calm = 1'b0;

        write_surfaces(DIM_W'($urandom_range(1, 16)), DIM_W'($urandom_range(1, 16)),
                       DIM_W'($urandom_range(1, 4096)), DIM_W'($urandom_range(1, 16)));
        random_phase(270);

        write_surfaces(DIM_W'($urandom_range(1, 4096)), DIM_W'($urandom_range(1, 4096)),
                       DIM_W'($urandom_range(1, 4096)), DIM_W'($urandom_range(1, 4096)));
        random_phase(270);

        drain_and_settle();
        $display("Sent %0d requests over %0d surface settings, with %0d long output hold.",
                 requests_sent, settings_used, holds_done);
        $display("Checked %0d pixel pairs, %0d blits reached their last pair, %0d mismatches.",
                 tracker.pairs_checked, tracker.blits_done, tracker.mismatches);
        if (tracker.mismatches == 0 && tracker.pending_pairs.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
